/* src/rcpf_pkg.sv */
// Shared types, constants and frame bytes of the radio channel packet framer.
package rcpf_pkg;

	localparam int unsigned NumCh    = 7;
	localparam int unsigned ChW      = 12;
	localparam int unsigned OffW     = 10;
	localparam int unsigned WordW    = 16;
	localparam int unsigned IdW      = 32;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned DataLen  = 20;
	localparam int unsigned BindLen  = 12;
	localparam int unsigned ByteIdxW = $clog2(DataLen);
	localparam int unsigned QDepth   = 2;
	localparam int unsigned QPtrW    = $clog2(QDepth);
	localparam int unsigned QCntW    = $clog2(QDepth + 1);

	localparam logic [CfgIdxW-1:0] CfgIdxId   = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgIdxOff0 = 3'd1;

	localparam logic OpData = 1'b0;
	localparam logic OpBind = 1'b1;

	localparam logic [WordW-1:0] ChannelBias = 16'h0280;

	localparam logic [7:0] DataLenByte = 8'h13;
	localparam logic [7:0] BindHdr0    = 8'h0b;
	localparam logic [7:0] BindHdr1    = 8'h7d;
	localparam logic [7:0] HdrOne      = 8'h01;
	localparam logic [7:0] ZeroByte    = 8'h00;

	typedef logic [ChW-1:0] chan_t;

	typedef struct packed {
		logic [IdW-1:0]                 id;
		logic [NumCh-1:0][OffW-1:0]     offset;
	} cfg_t;

	typedef struct packed {
		logic                           op;
		logic [NumCh-1:0][WordW-1:0]    word;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* src/rcpf_if.sv */
// Handshake channels of the framer: requests, frame words and register writes.
interface rcpf_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic signed [rcpf_pkg::ChW-1:0] channel_0;
	logic signed [rcpf_pkg::ChW-1:0] channel_1;
	logic signed [rcpf_pkg::ChW-1:0] channel_2;
	logic signed [rcpf_pkg::ChW-1:0] channel_3;
	logic signed [rcpf_pkg::ChW-1:0] channel_4;
	logic signed [rcpf_pkg::ChW-1:0] channel_5;
	logic signed [rcpf_pkg::ChW-1:0] channel_6;

	modport source(output valid, operation, channel_0, channel_1, channel_2, channel_3,
		channel_4, channel_5, channel_6, input ready);
	modport sink(input valid, operation, channel_0, channel_1, channel_2, channel_3,
		channel_4, channel_5, channel_6, output ready);
endinterface

interface rcpf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source(output valid, frame_byte, frame_end, input ready);
	modport sink(input valid, frame_byte, frame_end, output ready);
endinterface

interface rcpf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rcpf_pkg::CfgIdxW-1:0]     index;
	logic [rcpf_pkg::IdW-1:0]         data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/rcpf_cfg.sv */
// Configuration registers: transmitter ID and the seven centre offsets.
module rcpf_cfg (
	input  logic            clk,
	input  logic            arst_n,
	rcpf_cfg_if.sink        cfg,
	output rcpf_pkg::cfg_t  regs
);

	rcpf_pkg::cfg_t regs_q;
	logic [rcpf_pkg::CfgIdxW-1:0] off_sel;

	assign cfg.ready = 1'b1;
	assign off_sel   = cfg.index - rcpf_pkg::CfgIdxOff0;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == rcpf_pkg::CfgIdxId) begin
				regs_q.id <= cfg.data;
			end else begin
				regs_q.offset[off_sel] <= cfg.data[rcpf_pkg::OffW-1:0];
			end
		end
	end

endmodule

/* src/rcpf_front.sv */
// Front end: accepts requests and turns the channel positions into frame words.
module rcpf_front (
	rcpf_req_if.sink          req,
	input  rcpf_pkg::cfg_t    regs,
	input  rcpf_pkg::q_stat_t q_stat,
	output logic              push,
	output rcpf_pkg::entry_t  push_entry
);

	rcpf_pkg::chan_t [rcpf_pkg::NumCh-1:0] ch;
	logic [rcpf_pkg::ChW:0] rounded [rcpf_pkg::NumCh];

	assign ch[0] = req.channel_0;
	assign ch[1] = req.channel_1;
	assign ch[2] = req.channel_2;
	assign ch[3] = req.channel_3;
	assign ch[4] = req.channel_4;
	assign ch[5] = req.channel_5;
	assign ch[6] = req.channel_6;

	assign req.ready = !q_stat.full;
	assign push      = req.valid && req.ready;

	// Halving by a shift rounds down, so a negative position is bumped by one first to round toward zero.
	always_comb begin
		push_entry.op = req.operation;
		for (int i = 0; i < rcpf_pkg::NumCh; i++) begin
			rounded[i] = {ch[i][rcpf_pkg::ChW-1], ch[i]}
				+ {{rcpf_pkg::ChW{1'b0}}, ch[i][rcpf_pkg::ChW-1]};
			push_entry.word[i] =
				{{(rcpf_pkg::WordW - rcpf_pkg::ChW){rounded[i][rcpf_pkg::ChW]}},
					rounded[i][rcpf_pkg::ChW:1]}
				+ {{(rcpf_pkg::WordW - rcpf_pkg::OffW){regs.offset[i][rcpf_pkg::OffW-1]}},
					regs.offset[i]}
				+ rcpf_pkg::ChannelBias;
		end
	end

endmodule

/* src/rcpf_fifo.sv */
// Short request queue between the front end and the byte sequencer.
module rcpf_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rcpf_pkg::entry_t  push_entry,
	input  logic              pop,
	output rcpf_pkg::entry_t  head,
	output rcpf_pkg::q_stat_t q_stat
);

	rcpf_pkg::entry_t mem_q [rcpf_pkg::QDepth];
	logic [rcpf_pkg::QPtrW-1:0] wr_ptr_q;
	logic [rcpf_pkg::QPtrW-1:0] rd_ptr_q;
	logic [rcpf_pkg::QCntW-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = count_q == rcpf_pkg::QCntW'(rcpf_pkg::QDepth);
	assign q_stat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == rcpf_pkg::QPtrW'(rcpf_pkg::QDepth - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == rcpf_pkg::QPtrW'(rcpf_pkg::QDepth - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/rcpf_back.sv */
// Back end: builds the frame with its check bytes and sends it one byte per word.
module rcpf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rcpf_pkg::cfg_t    regs,
	input  rcpf_pkg::entry_t  head,
	input  rcpf_pkg::q_stat_t q_stat,
	output logic              pop,
	rcpf_byte_if.source       frm
);

	logic [rcpf_pkg::DataLen-1:0][7:0] frame_q;
	logic [rcpf_pkg::DataLen-1:0][7:0] frame_d;
	logic [rcpf_pkg::ByteIdxW-1:0]     idx_q;
	logic [rcpf_pkg::ByteIdxW-1:0]     last_q;
	logic [rcpf_pkg::ByteIdxW-1:0]     last_d;
	logic                              loaded_q;
	logic                              out_valid_q;
	logic [7:0]                        out_byte_q;
	logic                              out_end_q;
	logic                              adv;
	logic                              emit;
	logic                              at_last;
	logic [7:0]                        xor_a;
	logic [7:0]                        hi_sum;
	logic [7:0]                        id_b [4];

	assign frm.valid      = out_valid_q;
	assign frm.frame_byte = out_byte_q;
	assign frm.frame_end  = out_end_q;

	assign adv     = !out_valid_q || frm.ready;
	assign emit    = loaded_q && adv;
	assign at_last = idx_q == last_q;
	assign pop     = !q_stat.empty && (!loaded_q || (emit && at_last));

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			id_b[k] = regs.id[8*k +: 8];
		end
		xor_a  = '0;
		hi_sum = '0;
		for (int i = 0; i < rcpf_pkg::NumCh - 1; i++) begin
			xor_a  = xor_a ^ head.word[i][15:8] ^ head.word[i][7:0];
			hi_sum = hi_sum + head.word[i][15:8];
		end
		frame_d = '0;
		if (head.op == rcpf_pkg::OpBind) begin
			frame_d[0]  = rcpf_pkg::BindHdr0;
			frame_d[1]  = rcpf_pkg::BindHdr1;
			frame_d[2]  = rcpf_pkg::HdrOne;
			frame_d[3]  = rcpf_pkg::HdrOne;
			frame_d[4]  = id_b[3];
			frame_d[5]  = id_b[2];
			frame_d[6]  = id_b[1];
			frame_d[7]  = id_b[0];
			frame_d[8]  = rcpf_pkg::ZeroByte;
			frame_d[9]  = rcpf_pkg::ZeroByte;
			frame_d[10] = id_b[2];
			frame_d[11] = rcpf_pkg::HdrOne ^ id_b[3] ^ id_b[1] ^ id_b[0];
			last_d      = rcpf_pkg::ByteIdxW'(rcpf_pkg::BindLen - 1);
		end else begin
			frame_d[0] = rcpf_pkg::DataLenByte;
			frame_d[1] = id_b[2];
			frame_d[2] = rcpf_pkg::HdrOne;
			for (int i = 0; i < rcpf_pkg::NumCh; i++) begin
				frame_d[3 + 2*i] = head.word[i][15:8];
				frame_d[4 + 2*i] = head.word[i][7:0];
			end
			frame_d[17] = xor_a ^ head.word[6][15:8] ^ head.word[6][7:0];
			frame_d[18] = xor_a;
			frame_d[19] = hi_sum;
			last_d      = rcpf_pkg::ByteIdxW'(rcpf_pkg::DataLen - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= frame_d;
			last_q  <= last_d;
		end
		if (emit) begin
			out_byte_q <= frame_q[idx_q];
			out_end_q  <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			loaded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				loaded_q <= 1'b1;
				idx_q    <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
				if (at_last) begin
					loaded_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* src/rc_channel_packet_framer.sv */
// Top level of the radio channel packet framer.
// Each request on req becomes one frame on frm, one byte per word with frame_end on the
// last byte: 20 bytes for a data request, 12 for a bind request. The byte sequencer sends
// one byte per cycle while frm is ready and loads the next frame in the cycle its last byte
// goes out, so frames stream back to back. A two-entry queue lets new requests be taken
// while a frame is still being sent. An accepted request is written into the queue, then
// loaded into the frame register, then its first byte into the output register. Registers
// on cfg are written at once and must only change while no frame is in flight.
module rc_channel_packet_framer (
	input  logic         clk,
	input  logic         arst_n,
	rcpf_req_if.sink     req,
	rcpf_byte_if.source  frm,
	rcpf_cfg_if.sink     cfg
);

	rcpf_pkg::cfg_t    regs;
	rcpf_pkg::entry_t  push_entry;
	rcpf_pkg::entry_t  head;
	rcpf_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	rcpf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rcpf_front u_front (
		.req        (req),
		.regs       (regs),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	rcpf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	rcpf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.frm    (frm)
	);

endmodule
